/* hw/rtl/pses_pkg.sv */
// Shared types and constants for the prefix expression stack evaluator.
// No dependencies; used by pses_alu and the top level.
package pses_pkg;

	// Default sizes of the value stack
	localparam int STACK_DEPTH_DEF = 32;
	localparam int VALUE_WIDTH_DEF = 32;

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;

	// Error codes reported with each result
	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_DIV0  = 2'd1,
		ERR_UNDER = 2'd2,
		ERR_OVER  = 2'd3
	} err_t;

	// Operations of the shared arithmetic unit
	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_MOD
	} alu_op_t;

	// Request from the sequencer to the arithmetic unit
	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_TOP,
		ST_RD_NEXT,
		ST_EXEC,
		ST_CALC,
		ST_EMIT
	} seq_state_t;

	// Arithmetic unit states
	typedef enum logic [1:0] {
		AS_IDLE,
		AS_RUN,
		AS_FIX,
		AS_DONE
	} alu_state_t;

endpackage

/* hw/rtl/pses_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pses_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hw/rtl/pses_alu.sv */
// Iterative arithmetic unit around one shared adder: add, subtract,
// shift-add multiply and restoring divide/modulo. Depends on pses_pkg.
module pses_alu #(
	parameter int VALUE_WIDTH = pses_pkg::VALUE_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pses_pkg::alu_req_t      req,
	input  logic [VALUE_WIDTH-1:0]  a,
	input  logic [VALUE_WIDTH-1:0]  b,
	output logic                    done,
	output logic [VALUE_WIDTH-1:0]  result
);

	localparam int W  = VALUE_WIDTH;
	localparam int CW = $clog2(W + 1);

	pses_pkg::alu_state_t state_q, state_d;
	pses_pkg::alu_op_t    op_q;
	logic [W-1:0]         x_q, y_q, acc_q;
	logic [CW-1:0]        cnt_q;
	logic                 qneg_q, rneg_q;

	logic [W-1:0]         a_mag, b_mag;
	logic [W-1:0]         add_a, add_b;
	logic                 add_sub;
	logic [W:0]           sum;
	logic [W-1:0]         rem_sh;
	logic                 last_step;

	// Operand magnitudes for division
	assign a_mag = a[W-1] ? (~a + {{(W-1){1'b0}}, 1'b1}) : a;
	assign b_mag = b[W-1] ? (~b + {{(W-1){1'b0}}, 1'b1}) : b;

	assign rem_sh    = {acc_q[W-2:0], y_q[W-1]};
	assign last_step = (cnt_q == CW'(1));

	// Shared adder
	assign sum = {1'b0, add_a} + {1'b0, add_b ^ {W{add_sub}}} + {{W{1'b0}}, add_sub};

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pses_pkg::AS_IDLE: begin
				if (req.start) state_d = pses_pkg::AS_RUN;
			end
			pses_pkg::AS_RUN: begin
				case (op_q)
					pses_pkg::OP_ADD, pses_pkg::OP_SUB: state_d = pses_pkg::AS_DONE;
					pses_pkg::OP_MUL: if (last_step) state_d = pses_pkg::AS_DONE;
					default: if (last_step) state_d = pses_pkg::AS_FIX;
				endcase
			end
			pses_pkg::AS_FIX:  state_d = pses_pkg::AS_DONE;
			pses_pkg::AS_DONE: state_d = pses_pkg::AS_IDLE;
			default:           state_d = pses_pkg::AS_IDLE;
		endcase
	end

	// Adder operand selection and outputs
	always_comb begin
		add_a   = x_q;
		add_b   = y_q;
		add_sub = 1'b0;
		case (state_q)
			pses_pkg::AS_RUN: begin
				case (op_q)
					pses_pkg::OP_ADD: begin
						add_a = x_q;
						add_b = y_q;
					end
					pses_pkg::OP_SUB: begin
						add_a   = x_q;
						add_b   = y_q;
						add_sub = 1'b1;
					end
					pses_pkg::OP_MUL: begin
						add_a = acc_q;
						add_b = x_q;
					end
					default: begin
						add_a   = rem_sh;
						add_b   = x_q;
						add_sub = 1'b1;
					end
				endcase
			end
			pses_pkg::AS_FIX: begin
				add_a   = '0;
				add_b   = (op_q == pses_pkg::OP_DIV) ? y_q : acc_q;
				add_sub = 1'b1;
			end
			default: begin
				add_a   = x_q;
				add_b   = y_q;
				add_sub = 1'b0;
			end
		endcase
	end

	assign done   = (state_q == pses_pkg::AS_DONE);
	assign result = acc_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pses_pkg::AS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			pses_pkg::AS_IDLE: begin
				if (req.start) begin
					op_q   <= req.op;
					acc_q  <= '0;
					cnt_q  <= CW'(W);
					qneg_q <= a[W-1] ^ b[W-1];
					rneg_q <= a[W-1];
					if (req.op == pses_pkg::OP_DIV || req.op == pses_pkg::OP_MOD) begin
						x_q <= b_mag;
						y_q <= a_mag;
					end else begin
						x_q <= a;
						y_q <= b;
					end
				end
			end
			pses_pkg::AS_RUN: begin
				case (op_q)
					pses_pkg::OP_ADD, pses_pkg::OP_SUB: begin
						acc_q <= sum[W-1:0];
					end
					pses_pkg::OP_MUL: begin
						if (y_q[0]) acc_q <= sum[W-1:0];
						x_q   <= {x_q[W-2:0], 1'b0};
						y_q   <= {1'b0, y_q[W-1:1]};
						cnt_q <= cnt_q - CW'(1);
					end
					default: begin
						// Restore when the trial subtract borrows
						acc_q <= sum[W] ? sum[W-1:0] : rem_sh;
						y_q   <= {y_q[W-2:0], sum[W]};
						cnt_q <= cnt_q - CW'(1);
					end
				endcase
			end
			pses_pkg::AS_FIX: begin
				// Apply signs: quotient by operand signs, remainder by dividend
				if (op_q == pses_pkg::OP_DIV) begin
					acc_q <= qneg_q ? sum[W-1:0] : y_q;
				end else begin
					acc_q <= rneg_q ? sum[W-1:0] : acc_q;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

endmodule

/* hw/rtl/prefix_expression_stack_evaluator.sv */
// Prefix expression evaluator: stack RAM, sequencer, shared arithmetic unit.
// A push or parenthesis is handled in the idle state; NUL waits for the output to be free;
// + - * / % read two entries and run in the shared unit, but a divide by zero skips it.
// One transaction at a time; the next is taken once the sequencer is idle.
// Reset empties the stack and clears the error; stack contents are not cleared.
// Depends on pses_pkg, pses_ram, pses_alu.
module prefix_expression_stack_evaluator #(
	parameter int STACK_DEPTH = pses_pkg::STACK_DEPTH_DEF,
	parameter int VALUE_WIDTH = pses_pkg::VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        symbol_valid,
	output logic        symbol_stall,
	input  logic [7:0]  symbol_char,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [31:0] result_value,
	output logic [1:0]  error_code
);

	localparam int W  = VALUE_WIDTH;
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int LW = $clog2(STACK_DEPTH + 1);

	pses_pkg::seq_state_t state_q, state_d;
	pses_pkg::err_t       err_q;
	pses_pkg::alu_op_t    op_q;
	logic [LW-1:0]        level_q;
	logic                 nul_q;
	logic [W-1:0]         left_q;
	logic                 result_valid_q;
	logic [31:0]          result_value_q;
	pses_pkg::err_t       error_code_q;

	logic                 accept;
	logic                 is_nul, is_op, is_paren;
	pses_pkg::alu_op_t    char_op;
	logic                 have_two, full;
	logic [LW-1:0]        lvl_m1, lvl_m2;
	logic signed [8:0]    push_small;
	logic [W+8:0]         push_ext;
	logic [W-1:0]         rd_data, top_val;
	logic [W+31:0]        top_ext;
	logic                 div_zero, out_free;
	logic                 alu_done;
	logic [W-1:0]         alu_result;
	pses_pkg::alu_req_t   alu_req;

	logic                 rd_en, wr_en;
	logic [AW-1:0]        rd_addr, wr_addr;
	logic [W-1:0]         wr_data;
	logic                 lvl_inc, lvl_dec1, lvl_dec2, emit_load;
	logic                 note_en;
	pses_pkg::err_t       note_code;

	// Classify the incoming character
	always_comb begin
		is_nul   = 1'b0;
		is_op    = 1'b0;
		is_paren = 1'b0;
		char_op  = pses_pkg::OP_ADD;
		case (symbol_char) inside
			pses_pkg::CH_NUL:   is_nul = 1'b1;
			pses_pkg::CH_PLUS:  begin is_op = 1'b1; char_op = pses_pkg::OP_ADD; end
			pses_pkg::CH_MINUS: begin is_op = 1'b1; char_op = pses_pkg::OP_SUB; end
			pses_pkg::CH_STAR:  begin is_op = 1'b1; char_op = pses_pkg::OP_MUL; end
			pses_pkg::CH_SLASH: begin is_op = 1'b1; char_op = pses_pkg::OP_DIV; end
			pses_pkg::CH_PCT:   begin is_op = 1'b1; char_op = pses_pkg::OP_MOD; end
			pses_pkg::CH_LPAR, pses_pkg::CH_RPAR: is_paren = 1'b1;
			default:            is_nul = 1'b0;
		endcase
	end

	assign accept   = symbol_valid && !symbol_stall;
	assign have_two = (level_q >= LW'(2));
	assign full     = (level_q >= LW'(STACK_DEPTH));
	assign lvl_m1   = level_q - LW'(1);
	assign lvl_m2   = level_q - LW'(2);

	// Pushed value is the code minus 48, wrapped to the value width
	assign push_small = $signed({1'b0, symbol_char}) - $signed({1'b0, pses_pkg::CH_ZERO});
	assign push_ext   = {{W{push_small[8]}}, push_small};

	assign div_zero = (op_q == pses_pkg::OP_DIV || op_q == pses_pkg::OP_MOD) && (rd_data == '0);
	assign out_free = !result_valid_q || !result_stall;

	// Top of stack for the result, low 32 bits
	assign top_val = (level_q == '0) ? '0 : rd_data;
	assign top_ext = {32'b0, top_val};

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pses_pkg::ST_IDLE: begin
				if (symbol_valid) begin
					if (is_nul) begin
						state_d = (level_q == '0) ? pses_pkg::ST_EMIT : pses_pkg::ST_RD_TOP;
					end else if (is_op && have_two) begin
						state_d = pses_pkg::ST_RD_TOP;
					end
				end
			end
			pses_pkg::ST_RD_TOP:  state_d = nul_q ? pses_pkg::ST_EMIT : pses_pkg::ST_RD_NEXT;
			pses_pkg::ST_RD_NEXT: state_d = pses_pkg::ST_EXEC;
			pses_pkg::ST_EXEC:    state_d = div_zero ? pses_pkg::ST_IDLE : pses_pkg::ST_CALC;
			pses_pkg::ST_CALC: begin
				if (alu_done) state_d = pses_pkg::ST_IDLE;
			end
			pses_pkg::ST_EMIT: begin
				if (out_free) state_d = pses_pkg::ST_IDLE;
			end
			default: state_d = pses_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		symbol_stall  = (state_q != pses_pkg::ST_IDLE);
		rd_en         = 1'b0;
		rd_addr       = lvl_m1[AW-1:0];
		wr_en         = 1'b0;
		wr_addr       = lvl_m2[AW-1:0];
		wr_data       = alu_result;
		lvl_inc       = 1'b0;
		lvl_dec1      = 1'b0;
		lvl_dec2      = 1'b0;
		emit_load     = 1'b0;
		note_en       = 1'b0;
		note_code     = pses_pkg::ERR_NONE;
		alu_req.start = 1'b0;
		alu_req.op    = op_q;
		case (state_q)
			pses_pkg::ST_IDLE: begin
				if (accept && !is_nul) begin
					if (is_op || is_paren) begin
						if (!have_two) begin
							note_en   = 1'b1;
							note_code = pses_pkg::ERR_UNDER;
						end else if (is_paren) begin
							lvl_dec2 = 1'b1;
						end
					end else if (full) begin
						note_en   = 1'b1;
						note_code = pses_pkg::ERR_OVER;
					end else begin
						wr_en   = 1'b1;
						wr_addr = level_q[AW-1:0];
						wr_data = push_ext[W-1:0];
						lvl_inc = 1'b1;
					end
				end
			end
			pses_pkg::ST_RD_TOP: begin
				rd_en   = 1'b1;
				rd_addr = lvl_m1[AW-1:0];
			end
			pses_pkg::ST_RD_NEXT: begin
				rd_en   = 1'b1;
				rd_addr = lvl_m2[AW-1:0];
			end
			pses_pkg::ST_EXEC: begin
				if (div_zero) begin
					note_en   = 1'b1;
					note_code = pses_pkg::ERR_DIV0;
					wr_en     = 1'b1;
					wr_data   = '0;
					lvl_dec1  = 1'b1;
				end else begin
					alu_req.start = 1'b1;
				end
			end
			pses_pkg::ST_CALC: begin
				if (alu_done) begin
					wr_en    = 1'b1;
					lvl_dec1 = 1'b1;
				end
			end
			pses_pkg::ST_EMIT: begin
				emit_load = out_free;
			end
			default: symbol_stall = 1'b1;
		endcase
	end

	// Control state: sequencer, stack level, first error, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= pses_pkg::ST_IDLE;
			level_q        <= '0;
			err_q          <= pses_pkg::ERR_NONE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_load) begin
				level_q <= '0;
				err_q   <= pses_pkg::ERR_NONE;
			end else begin
				if (lvl_inc)  level_q <= level_q + LW'(1);
				if (lvl_dec1) level_q <= lvl_m1;
				if (lvl_dec2) level_q <= lvl_m2;
				if (note_en && err_q == pses_pkg::ERR_NONE) err_q <= note_code;
			end
			if (emit_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			nul_q <= is_nul;
			op_q  <= char_op;
		end
		if (state_q == pses_pkg::ST_RD_NEXT) begin
			left_q <= rd_data;
		end
		if (emit_load) begin
			result_value_q <= top_ext[31:0];
			error_code_q   <= (level_q == '0 && err_q == pses_pkg::ERR_NONE) ?
				pses_pkg::ERR_UNDER : err_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result_value = result_value_q;
	assign error_code   = error_code_q;

	pses_ram #(
		.WIDTH(W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	pses_alu #(
		.VALUE_WIDTH(W)
	) u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.a     (left_q),
		.b     (rd_data),
		.done  (alu_done),
		.result(alu_result)
	);

	// Stack level never passes the depth
	assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LW'(STACK_DEPTH))
		else $error("stack level beyond depth");

	// Arithmetic results only arrive while the sequencer waits for them
	assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> state_q == pses_pkg::ST_CALC)
		else $error("arithmetic result outside wait state");

	// Emitting a result empties the stack and clears the error
	assert property (@(posedge clk) disable iff (!arst_n)
		emit_load |=> (level_q == '0 && err_q == pses_pkg::ERR_NONE && result_valid_q))
		else $error("stack not emptied after result");

	// A new result only appears out of the emit state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q) == pses_pkg::ST_EMIT)
		else $error("result raised outside emit state");

endmodule

/* dv/prefix_expression_stack_evaluator_tb.sv */
// Self-checking testbench for the prefix expression stack evaluator: drives reversed prefix
// expressions and checks every emitted result against an in-bench stack predictor.
// Depends on pses_pkg and prefix_expression_stack_evaluator.
module prefix_expression_stack_evaluator_tb;
	import pses_pkg::*;

	localparam int STACK_LIMIT  = STACK_DEPTH_DEF;
	localparam int ITEM_TARGET  = 1200;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int SETTLE_TICKS = 100;

	// One expected result of an expression
	typedef struct packed {
		logic [31:0] value;
		err_t        code;
	} expr_result_t;

	// Stack predictor plus the queue of results it still owes
	class expr_scoreboard;
		logic [31:0]  operand_stack [STACK_LIMIT];
		int           depth_used;
		err_t         first_err;
		expr_result_t pending [$];
		int           mismatches;
		int           results_seen;
		int           chars_taken;
		int           code_hits [4];

		function new();
			depth_used = 0;
			first_err = ERR_NONE;
			mismatches = 0;
			results_seen = 0;
			chars_taken = 0;
			foreach (code_hits[i]) code_hits[i] = 0;
		endfunction

		// Operators and parentheses both pop two entries
		static function bit pops_two(logic [7:0] c);
			case (c)
				CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_LPAR, CH_RPAR: return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		function void note_error(err_t code);
			if (first_err == ERR_NONE) first_err = code;
		endfunction

		// Drop the value on a full stack
		function void push_operand(logic [31:0] v);
			if (depth_used >= STACK_LIMIT) begin
				note_error(ERR_OVER);
				return;
			end
			operand_stack[depth_used] = v;
			depth_used++;
		endfunction

		// Wrap at 32 bits; divide and modulo truncate toward zero on magnitudes
		function logic [31:0] apply_op(logic [7:0] op, logic [31:0] lhs, logic [31:0] rhs);
			logic [31:0] mag_l;
			logic [31:0] mag_r;
			logic [31:0] q;
			case (op)
				CH_PLUS:  return lhs + rhs;
				CH_MINUS: return lhs - rhs;
				CH_STAR:  return lhs * rhs;
				default:  ;
			endcase
			if (rhs == 32'd0) begin
				note_error(ERR_DIV0);
				return 32'd0;
			end
			mag_l = lhs[31] ? -lhs : lhs;
			mag_r = rhs[31] ? -rhs : rhs;
			if (op == CH_SLASH) begin
				q = mag_l / mag_r;
				return (lhs[31] != rhs[31]) ? -q : q;
			end
			q = mag_l % mag_r;
			return lhs[31] ? -q : q;
		endfunction

		// Advance the predicted state by one accepted character
		function void take_char(logic [7:0] c);
			logic [31:0]  lhs;
			logic [31:0]  rhs;
			logic [31:0]  top;
			expr_result_t res;
			chars_taken++;
			if (c == CH_NUL) begin
				if (depth_used == 0) begin
					note_error(ERR_UNDER);
					top = 32'd0;
				end else begin
					top = operand_stack[depth_used - 1];
				end
				res.value = top;
				res.code = first_err;
				pending.push_back(res);
				depth_used = 0;
				first_err = ERR_NONE;
				return;
			end
			if (pops_two(c)) begin
				if (depth_used < 2) begin
					note_error(ERR_UNDER);
					return;
				end
				lhs = operand_stack[depth_used - 1];
				rhs = operand_stack[depth_used - 2];
				depth_used -= 2;
				if (c != CH_LPAR && c != CH_RPAR) push_operand(apply_op(c, lhs, rhs));
				return;
			end
			push_operand({24'd0, c} - {24'd0, CH_ZERO});
		endfunction

		// Compare one result with the oldest expectation
		function void match_result(logic [31:0] value, logic [1:0] code);
			expr_result_t exp_res;
			if (pending.size() == 0) begin
				$error("result with no expression pending: result_value %0d error_code %0d",
					$signed(value), code);
				mismatches++;
				return;
			end
			exp_res = pending.pop_front();
			results_seen++;
			code_hits[exp_res.code]++;
			if (value !== exp_res.value) begin
				$error("result_value expected %0d actual %0d", $signed(exp_res.value),
					$signed(value));
				mismatches++;
			end
			if (code !== exp_res.code) begin
				$error("error_code expected %0d actual %0d", exp_res.code, code);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        symbol_valid;
	logic        symbol_stall;
	logic [7:0]  symbol_char;
	logic        result_valid;
	logic        result_stall;
	logic [31:0] result_value;
	logic [1:0]  error_code;

	bit             steady = 1'b0;
	int             cycle_count = 0;
	int             chars_sent = 0;
	expr_scoreboard board = new();

	prefix_expression_stack_evaluator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.symbol_valid (symbol_valid),
		.symbol_stall (symbol_stall),
		.symbol_char  (symbol_char),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_value (result_value),
		.error_code   (error_code)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check each result transaction, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) board.match_result(result_value, error_code);
		result_stall <= !steady && ($urandom_range(99) < 28);
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("prefix_expression_stack_evaluator verification failed");
			$finish;
		end
	end

	// Offer one character, hold it until taken, then note it
	task automatic send_char(input logic [7:0] c);
		while (!steady && $urandom_range(99) < 28) begin
			symbol_valid <= 1'b0;
			@(posedge clk);
		end
		symbol_valid <= 1'b1;
		symbol_char <= c;
		@(posedge clk);
		while (symbol_stall) @(posedge clk);
		board.take_char(c);
		chars_sent++;
	endtask

	// Drop valid and hold off until every expected result has come back
	task automatic wait_drained();
		symbol_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	// Mostly digits, with zeros often enough to divide by zero
	function automatic logic [7:0] pick_operand();
		logic [7:0] c;
		if ($urandom_range(99) < 70) return CH_ZERO + 8'($urandom_range(9));
		c = 8'($urandom_range(1, 255));
		while (expr_scoreboard::pops_two(c)) c = 8'($urandom_range(1, 255));
		return c;
	endfunction

	function automatic logic [7:0] pick_operator();
		case ($urandom_range(9))
			0, 1:    return CH_PLUS;
			2, 3:    return CH_MINUS;
			4, 5:    return CH_STAR;
			6:       return CH_SLASH;
			7:       return CH_PCT;
			8:       return CH_LPAR;
			default: return CH_RPAR;
		endcase
	endfunction

	// Reversed prefix expression: burst pushes first, then mixed
	task automatic send_expression(input int operands, input int burst);
		int         level;
		int         to_push;
		logic [7:0] op;
		level = 0;
		to_push = operands;
		repeat (burst) begin
			send_char(pick_operand());
			level++;
			to_push--;
		end
		while (to_push > 0 || level > 1) begin
			if (level >= 2 && (to_push == 0 || $urandom_range(2) == 0)) begin
				op = pick_operator();
				send_char(op);
				level -= (op == CH_LPAR || op == CH_RPAR) ? 2 : 1;
			end else begin
				send_char(pick_operand());
				level++;
				to_push--;
			end
		end
		send_char(CH_NUL);
	endtask

	// Build -1 under the most negative value, then divide or take the remainder
	task automatic send_wrap_case(input logic [7:0] op);
		send_char(CH_ZERO + 8'd1);
		send_char(CH_ZERO);
		send_char(CH_MINUS);
		send_char(CH_ZERO + 8'd128);
		send_char(CH_ZERO + 8'd128);
		send_char(CH_STAR);
		send_char(CH_ZERO + 8'd128);
		send_char(CH_STAR);
		send_char(CH_ZERO + 8'd128);
		send_char(CH_STAR);
		send_char(CH_ZERO + 8'd8);
		send_char(CH_STAR);
		send_char(op);
		send_char(CH_NUL);
	endtask

	// Arbitrary characters, closed by a NUL
	task automatic send_noise(input int count);
		repeat (count) send_char(8'($urandom_range(255)));
		send_char(CH_NUL);
	endtask

	initial begin
		int pick;
		int burst;
		int next_drain;
		arst_n <= 1'b0;
		symbol_valid <= 1'b0;
		symbol_char <= CH_NUL;
		result_stall <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// End on an empty stack
		send_char(CH_NUL);
		// Character extremes, remainder, divide by zero, then parentheses and underflow
		send_char(CH_ZERO);
		send_char(8'h01);
		send_char(8'hFF);
		send_char(CH_PCT);
		send_char(CH_SLASH);
		send_char(CH_ZERO + 8'd9);
		send_char(CH_PLUS);
		send_char(CH_ZERO + 8'd5);
		send_char(CH_LPAR);
		send_char(CH_RPAR);
		send_char(CH_NUL);
		// Most negative value divided by -1
		send_wrap_case(CH_SLASH);

		// Random expressions, with a quiet stretch and periodic drains
		next_drain = 300;
		while (chars_sent < ITEM_TARGET) begin
			steady = (chars_sent >= 500 && chars_sent < 700);
			if (chars_sent >= next_drain) begin
				wait_drained();
				next_drain += 300;
			end
			pick = $urandom_range(99);
			if (pick < 60) begin
				send_expression($urandom_range(1, 10), 0);
			end else if (pick < 68) begin
				burst = $urandom_range(30, 36);
				send_expression(burst + $urandom_range(0, 3), burst);
			end else if (pick < 75) begin
				send_wrap_case($urandom_range(1) ? CH_SLASH : CH_PCT);
			end else begin
				send_noise($urandom_range(1, 8));
			end
		end
		steady = 1'b0;
		symbol_valid <= 1'b0;

		wait_drained();
		repeat (SETTLE_TICKS) @(posedge clk);
		$display("Sent %0d characters and checked %0d expression results.",
			board.chars_taken, board.results_seen);
		$display("Results by error code: ok %0d, divide by zero %0d, underflow %0d, overflow %0d.",
			board.code_hits[ERR_NONE], board.code_hits[ERR_DIV0], board.code_hits[ERR_UNDER],
			board.code_hits[ERR_OVER]);
		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("prefix_expression_stack_evaluator verification clean");
		end else begin
			$display("prefix_expression_stack_evaluator verification failed");
		end
		$finish;
	end

endmodule

/* files.f */
hw/rtl/pses_pkg.sv
hw/rtl/pses_ram.sv
hw/rtl/pses_alu.sv
hw/rtl/prefix_expression_stack_evaluator.sv
dv/prefix_expression_stack_evaluator_tb.sv
